FILE: rtl/core/grc_pkg.sv
// grc_pkg: shared types, codes and constants of the grid ray caster
// no dependencies; imported by grc_datapath, grc_ctrl, the top level and the bench
`timescale 1ns / 1ps

package grc_pkg;

    localparam logic [1:0] MODE_WRITE  = 2'd0;
    localparam logic [1:0] MODE_CAST   = 2'd1;
    localparam logic [1:0] MODE_EXTENT = 2'd2;

    localparam logic [3:0] REG_POS_FIRST     = 4'd0;
    localparam logic [3:0] REG_POS_SECOND    = 4'd1;
    localparam logic [3:0] REG_DIR_FIRST     = 4'd2;
    localparam logic [3:0] REG_DIR_SECOND    = 4'd3;
    localparam logic [3:0] REG_PLANE_FIRST   = 4'd4;
    localparam logic [3:0] REG_PLANE_SECOND  = 4'd5;
    localparam logic [3:0] REG_SCREEN_WIDTH  = 4'd6;
    localparam logic [3:0] REG_SCREEN_HEIGHT = 4'd7;

    localparam logic [3:0] TEX_FIRST_LOW   = 4'd0;
    localparam logic [3:0] TEX_FIRST_HIGH  = 4'd1;
    localparam logic [3:0] TEX_SECOND_LOW  = 4'd4;
    localparam logic [3:0] TEX_SECOND_HIGH = 4'd3;

    localparam logic [31:0] DIST_MAX   = 32'hFFFF_FFFF;
    localparam logic [15:0] LH_MAX     = 16'hFFFF;
    localparam logic [12:0] HEIGHT_MAX = 13'd4096;
    localparam logic [12:0] WIDTH_RST  = 13'd640;
    localparam logic [12:0] HEIGHT_RST = 13'd480;
    localparam int          EXTENT_RST = 64;

    typedef struct packed {
        logic [1:0]  mode;
        logic [5:0]  cell_first;
        logic [5:0]  cell_second;
        logic [3:0]  cell_value;
        logic [6:0]  extent_first;
        logic [6:0]  extent_second;
        logic [11:0] column;
    } in_item_t;

    typedef struct packed {
        logic [31:0] perp_dist;
        logic [15:0] line_height;
        logic [11:0] draw_start;
        logic [11:0] draw_end;
        logic        hit_side;
        logic [5:0]  hit_first;
        logic [5:0]  hit_second;
        logic [3:0]  texture_index;
        logic        no_wall;
    } out_item_t;

    typedef struct packed {
        logic [3:0]  index;
        logic [31:0] data;
    } cfg_beat_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_WALK_STEP,
        S_WALK_CHK,
        S_WALK_TEST,
        S_OUT
    } state_t;

    typedef enum logic [2:0] {
        OP_CAM,
        OP_RAY,
        OP_DELTA,
        OP_SIDE,
        OP_PERP,
        OP_LH
    } op_t;

    typedef struct packed {
        logic clr_step;
        logic accept;
        logic start;
        op_t  op;
        logic axis;
        logic capture;
        logic walk_step;
        logic miss;
        logic hit;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic done;
        logic out_of_map;
        logic cell_nz;
        logic walk_limit;
        logic out_full;
    } status_t;

endpackage

FILE: rtl/core/grc_stream_if.sv
// grc_stream_if: valid/ready channel with a typed payload
// depends on nothing; payload types come from grc_pkg at instantiation
`timescale 1ns / 1ps

interface grc_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/core/grc_ram.sv
// grc_ram: generic single write port, single read port memory, registered read
// no dependencies
`timescale 1ns / 1ps

module grc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 4096
)(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/grc_mul.sv
// grc_mul: shift-add unsigned multiplier, one multiplier bit per cycle
// no dependencies; used by grc_datapath
`timescale 1ns / 1ps

module grc_mul #(
    parameter int AW = 18,
    parameter int BW = 32
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic             done,
    output logic [AW+BW-1:0] prod
);

    localparam int CNTW = $clog2(AW);

    logic [AW-1:0]    a_reg;
    logic [AW+BW-1:0] b_reg;
    logic [AW+BW-1:0] acc_reg;
    logic [CNTW-1:0]  cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CNTW'(1);
            if (cnt_reg == CNTW'(AW - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= (AW+BW)'(b);
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (a_reg[0])
            begin
                acc_reg <= acc_reg + b_reg;
            end
            a_reg <= a_reg >> 1;
            b_reg <= b_reg << 1;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

FILE: rtl/core/grc_div.sv
// grc_div: restoring unsigned divider, one quotient bit per cycle
// no dependencies; a zero divisor yields an all-ones quotient
`timescale 1ns / 1ps

module grc_div #(
    parameter int NW = 50,
    parameter int DW = 32
)(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo
);

    localparam int CNTW = $clog2(NW);

    logic [NW-1:0]   num_reg;
    logic [DW-1:0]   den_reg;
    logic [DW-1:0]   rem_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [DW:0]     trial;
    logic            qbit;

    always_comb
    begin
        trial = {rem_reg, num_reg[NW-1]};
        qbit  = (trial >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CNTW'(1);
            if (cnt_reg == CNTW'(NW - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NW-2:0], qbit};
            if (qbit)
            begin
                rem_reg <= DW'(trial - {1'b0, den_reg});
            end
            else
            begin
                rem_reg <= trial[DW-1:0];
            end
        end
    end

    assign done = done_reg;
    assign quo  = num_reg;

endmodule

FILE: rtl/core/grc_datapath.sv
// grc_datapath: config registers, grid memory, ray setup, dda walk and result
// depends on grc_pkg, grc_ram, grc_mul, grc_div
`timescale 1ns / 1ps

module grc_datapath
    import grc_pkg::*;
#(
    parameter int MAP_FIRST_MAX  = 64,
    parameter int MAP_SECOND_MAX = 64,
    parameter int FRAC_BITS      = 16
)(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_t      cmd,
    output status_t   st,
    input  in_item_t  item_data,
    input  logic      cfg_we,
    input  cfg_beat_t cfg_data,
    input  logic      out_ready,
    output logic      out_valid,
    output out_item_t out_data
);

    localparam int FA         = $clog2(MAP_FIRST_MAX);
    localparam int SA         = $clog2(MAP_SECOND_MAX);
    localparam int MAW        = FA + SA;
    localparam int DEPTH      = 1 << MAW;
    localparam int EW0        = $clog2(MAP_FIRST_MAX + 1);
    localparam int EW1        = $clog2(MAP_SECOND_MAX + 1);
    localparam int EXT0_RST   = (MAP_FIRST_MAX < EXTENT_RST) ? MAP_FIRST_MAX : EXTENT_RST;
    localparam int EXT1_RST   = (MAP_SECOND_MAX < EXTENT_RST) ? MAP_SECOND_MAX : EXTENT_RST;
    localparam int WALK_BOUND = MAP_FIRST_MAX + MAP_SECOND_MAX;
    localparam int CNW        = $clog2(WALK_BOUND + 1);
    localparam int CW         = ((32 - FRAC_BITS) > 9 ? (32 - FRAC_BITS) : 9) + 2;
    localparam int CMW        = 14 + FRAC_BITS;
    localparam int RW         = 33;
    localparam int AW         = (FRAC_BITS + 1 > 18) ? FRAC_BITS + 1 : 18;
    localparam int BW         = (13 + FRAC_BITS > 32) ? 13 + FRAC_BITS : 32;
    localparam int PW         = AW + BW;
    localparam int NW         = 34 + FRAC_BITS;
    localparam int DW         = 32;

    // configuration and map extent
    logic [31:0]        pos_reg [2];
    logic signed [17:0] dir_reg [2];
    logic signed [17:0] pln_reg [2];
    logic [12:0]        width_reg;
    logic [12:0]        height_reg;
    logic [EW0-1:0]     ext_first_reg;
    logic [EW1-1:0]     ext_second_reg;

    // clearing pass and output register
    logic [MAW-1:0]     clr_cnt_reg;
    logic               out_valid_reg;
    out_item_t          out_reg;
    out_item_t          out_next;

    // cast working registers
    logic [11:0]         col_reg;
    logic signed [CMW-1:0] cam_reg;
    logic signed [RW-1:0]  ray_reg [2];
    logic [31:0]         delta_reg [2];
    logic [31:0]         sided_reg [2];
    logic signed [CW-1:0]  cell_reg [2];
    logic                side_reg;
    logic [CNW-1:0]      cnt_reg;
    logic [3:0]          hit_val_reg;
    logic                miss_reg;
    logic [31:0]         perp_reg;
    logic [15:0]         lh_reg;

    // memory ports
    logic            ram_we;
    logic [MAW-1:0]  ram_waddr;
    logic [3:0]      ram_wdata;
    logic [MAW-1:0]  ram_raddr;
    logic [3:0]      ram_rdata;
    logic [8:0]      wr_first;
    logic [8:0]      wr_second;
    logic            wr_ok;

    // arithmetic units
    logic            mul_start;
    logic [AW-1:0]   mul_a;
    logic [BW-1:0]   mul_b;
    logic            mul_done;
    logic [PW-1:0]   mul_p;
    logic            div_start;
    logic [NW-1:0]   div_num;
    logic [DW-1:0]   div_den;
    logic            div_done;
    logic [NW-1:0]   div_q;

    // derived values
    logic [12:0]       width_eff;
    logic [12:0]       height_eff;
    logic              neg [2];
    logic [31:0]       ray_mag [2];
    logic [FRAC_BITS:0] frac [2];
    logic [17:0]       pln_mag;
    logic [CMW-1:0]    cam_mag;
    logic signed [PW:0] prod_s;
    logic signed [PW:0] prod_sh;
    logic [9:0]        bnd_idx;
    logic signed [33:0] pnum;
    logic [33:0]       pnum_mag;
    logic              sel;
    logic [32:0]       side_sum;
    logic [8:0]        ext0_in;
    logic [8:0]        ext1_in;
    logic [EW0-1:0]    ext0_new;
    logic [EW1-1:0]    ext1_new;

    always_comb
    begin
        width_eff = (width_reg == '0) ? 13'd1 : width_reg;
        if (height_reg == '0)
        begin
            height_eff = 13'd1;
        end
        else if (height_reg > HEIGHT_MAX)
        begin
            height_eff = HEIGHT_MAX;
        end
        else
        begin
            height_eff = height_reg;
        end
        for (int k = 0; k < 2; k++)
        begin
            neg[k]     = ray_reg[k][RW-1];
            ray_mag[k] = neg[k] ? 32'(-ray_reg[k]) : 32'(ray_reg[k]);
            if (neg[k])
            begin
                frac[k] = {1'b0, pos_reg[k][FRAC_BITS-1:0]};
            end
            else
            begin
                frac[k] = (FRAC_BITS+1)'(1 << FRAC_BITS)
                        - {1'b0, pos_reg[k][FRAC_BITS-1:0]};
            end
        end
        pln_mag = pln_reg[cmd.axis][17] ? 18'(-pln_reg[cmd.axis]) : 18'(pln_reg[cmd.axis]);
        cam_mag = cam_reg[CMW-1] ? CMW'(-cam_reg) : CMW'(cam_reg);
        if (pln_reg[cmd.axis][17] ^ cam_reg[CMW-1])
        begin
            prod_s = -$signed({1'b0, mul_p});
        end
        else
        begin
            prod_s = $signed({1'b0, mul_p});
        end
        prod_sh = prod_s >>> FRAC_BITS;

        // distance from viewer to the crossed boundary, along the hit axis
        bnd_idx  = {1'b0, cell_reg[side_reg][8:0]} + 10'(neg[side_reg]);
        pnum     = $signed(34'(bnd_idx) << FRAC_BITS) - $signed({2'b00, pos_reg[side_reg]});
        pnum_mag = pnum[33] ? 34'(-pnum) : 34'(pnum);

        sel      = (sided_reg[0] < sided_reg[1]) ? 1'b0 : 1'b1;
        side_sum = {1'b0, sided_reg[sel]} + {1'b0, delta_reg[sel]};

        ext0_in  = {2'b00, item_data.extent_first};
        ext1_in  = {2'b00, item_data.extent_second};
        if (ext0_in == '0)
        begin
            ext0_new = EW0'(1);
        end
        else if (ext0_in > 9'(MAP_FIRST_MAX))
        begin
            ext0_new = EW0'(MAP_FIRST_MAX);
        end
        else
        begin
            ext0_new = EW0'(ext0_in);
        end
        if (ext1_in == '0)
        begin
            ext1_new = EW1'(1);
        end
        else if (ext1_in > 9'(MAP_SECOND_MAX))
        begin
            ext1_new = EW1'(MAP_SECOND_MAX);
        end
        else
        begin
            ext1_new = EW1'(ext1_in);
        end
    end

    // unit operand selection
    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        div_num   = '0;
        div_den   = '0;
        mul_start = 1'b0;
        div_start = 1'b0;
        case (cmd.op)
            OP_CAM:
            begin
                div_start = cmd.start;
                div_num   = NW'({col_reg, 1'b0}) << FRAC_BITS;
                div_den   = DW'(width_eff);
            end
            OP_RAY:
            begin
                mul_start = cmd.start;
                mul_a     = AW'(pln_mag);
                mul_b     = BW'(cam_mag);
            end
            OP_DELTA:
            begin
                div_start = cmd.start;
                div_num   = NW'(1) << (2 * FRAC_BITS);
                div_den   = ray_mag[cmd.axis];
            end
            OP_SIDE:
            begin
                mul_start = cmd.start;
                mul_a     = AW'(frac[cmd.axis]);
                mul_b     = BW'(delta_reg[cmd.axis]);
            end
            OP_PERP:
            begin
                div_start = cmd.start;
                div_num   = NW'(pnum_mag) << FRAC_BITS;
                div_den   = ray_mag[side_reg];
            end
            OP_LH:
            begin
                div_start = cmd.start;
                div_num   = NW'(height_eff) << FRAC_BITS;
                div_den   = perp_reg;
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    grc_mul #(.AW(AW), .BW(BW)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_p)
    );

    grc_div #(.NW(NW), .DW(DW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_q)
    );

    // grid memory
    always_comb
    begin
        wr_first  = {3'b000, item_data.cell_first};
        wr_second = {3'b000, item_data.cell_second};
        wr_ok     = (wr_first < 9'(MAP_FIRST_MAX)) && (wr_second < 9'(MAP_SECOND_MAX));
        if (cmd.clr_step)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = cmd.accept && (item_data.mode == MODE_WRITE) && wr_ok;
            ram_waddr = {wr_first[FA-1:0], wr_second[SA-1:0]};
            ram_wdata = item_data.cell_value;
        end
        ram_raddr = {cell_reg[0][FA-1:0], cell_reg[1][SA-1:0]};
    end

    grc_ram #(.WIDTH(4), .DEPTH(DEPTH)) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // status to the controller
    always_comb
    begin
        st.clr_last   = (clr_cnt_reg == '1);
        st.done       = mul_done | div_done;
        st.out_of_map = cell_reg[0][CW-1] || cell_reg[1][CW-1]
                     || ($unsigned(cell_reg[0]) >= CW'(ext_first_reg))
                     || ($unsigned(cell_reg[1]) >= CW'(ext_second_reg));
        st.cell_nz    = (ram_rdata != '0);
        st.walk_limit = (cnt_reg == CNW'(WALK_BOUND));
        st.out_full   = out_valid_reg && !out_ready;
    end

    // result assembly
    logic [3:0]  tex;
    logic [11:0] half_h;
    logic [14:0] half_l;
    logic [15:0] end_sum;

    always_comb
    begin
        out_next = '0;
        tex      = hit_val_reg - 4'd1;
        half_h   = height_eff[12:1];
        half_l   = lh_reg[15:1];
        end_sum  = 16'(half_h) + 16'(half_l);
        if (cell_reg[0] == '0)
        begin
            tex = TEX_FIRST_LOW;
        end
        if ($unsigned(cell_reg[0]) == CW'(ext_first_reg) - CW'(1))
        begin
            tex = TEX_FIRST_HIGH;
        end
        if (cell_reg[1] == '0)
        begin
            tex = TEX_SECOND_LOW;
        end
        if ($unsigned(cell_reg[1]) == CW'(ext_second_reg) - CW'(1))
        begin
            tex = TEX_SECOND_HIGH;
        end
        if (miss_reg)
        begin
            out_next.perp_dist = DIST_MAX;
            out_next.no_wall   = 1'b1;
        end
        else
        begin
            out_next.perp_dist   = perp_reg;
            out_next.line_height = lh_reg;
            out_next.draw_start  = (15'(half_h) < half_l) ? 12'd0 : 12'(15'(half_h) - half_l);
            out_next.draw_end    = (end_sum >= 16'(height_eff))
                                 ? 12'(height_eff - 13'd1) : 12'(end_sum);
            out_next.hit_side      = side_reg;
            out_next.hit_first     = cell_reg[0][5:0];
            out_next.hit_second    = cell_reg[1][5:0];
            out_next.texture_index = tex;
            out_next.no_wall       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg[0]     <= '0;
            pos_reg[1]     <= '0;
            dir_reg[0]     <= '0;
            dir_reg[1]     <= '0;
            pln_reg[0]     <= '0;
            pln_reg[1]     <= '0;
            width_reg      <= WIDTH_RST;
            height_reg     <= HEIGHT_RST;
            ext_first_reg  <= EW0'(EXT0_RST);
            ext_second_reg <= EW1'(EXT1_RST);
            clr_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_data.index)
                    REG_POS_FIRST:     pos_reg[0] <= cfg_data.data;
                    REG_POS_SECOND:    pos_reg[1] <= cfg_data.data;
                    REG_DIR_FIRST:     dir_reg[0] <= cfg_data.data[17:0];
                    REG_DIR_SECOND:    dir_reg[1] <= cfg_data.data[17:0];
                    REG_PLANE_FIRST:   pln_reg[0] <= cfg_data.data[17:0];
                    REG_PLANE_SECOND:  pln_reg[1] <= cfg_data.data[17:0];
                    REG_SCREEN_WIDTH:  width_reg  <= cfg_data.data[12:0];
                    REG_SCREEN_HEIGHT: height_reg <= cfg_data.data[12:0];
                    default:           width_reg  <= width_reg;
                endcase
            end
            if (cmd.accept && item_data.mode == MODE_EXTENT)
            begin
                ext_first_reg  <= ext0_new;
                ext_second_reg <= ext1_new;
            end
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + MAW'(1);
            end
            out_valid_reg <= cmd.out_load || (out_valid_reg && !out_ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && item_data.mode == MODE_CAST)
        begin
            col_reg  <= item_data.column;
            miss_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        if (cmd.capture)
        begin
            case (cmd.op)
                OP_CAM:
                begin
                    cam_reg     <= CMW'({1'b0, div_q[CMW-2:0]}) - CMW'(1 << FRAC_BITS);
                    cell_reg[0] <= CW'(pos_reg[0] >> FRAC_BITS);
                    cell_reg[1] <= CW'(pos_reg[1] >> FRAC_BITS);
                end
                OP_RAY:
                begin
                    ray_reg[cmd.axis] <= RW'(dir_reg[cmd.axis]) + $signed(prod_sh[RW-1:0]);
                end
                OP_DELTA:
                begin
                    delta_reg[cmd.axis] <= (|div_q[NW-1:32]) ? DIST_MAX : div_q[31:0];
                end
                OP_SIDE:
                begin
                    sided_reg[cmd.axis] <= (|mul_p[PW-1:32+FRAC_BITS])
                                         ? DIST_MAX : mul_p[31+FRAC_BITS:FRAC_BITS];
                end
                OP_PERP:
                begin
                    perp_reg <= (|div_q[NW-1:32]) ? DIST_MAX : div_q[31:0];
                end
                OP_LH:
                begin
                    lh_reg <= (|div_q[NW-1:16]) ? LH_MAX : div_q[15:0];
                end
                default:
                begin
                    lh_reg <= lh_reg;
                end
            endcase
        end
        if (cmd.walk_step)
        begin
            sided_reg[sel] <= side_sum[32] ? DIST_MAX : side_sum[31:0];
            cell_reg[sel]  <= neg[sel] ? cell_reg[sel] - CW'(1) : cell_reg[sel] + CW'(1);
            side_reg       <= sel;
            cnt_reg        <= cnt_reg + CNW'(1);
        end
        if (cmd.hit)
        begin
            hit_val_reg <= ram_rdata;
        end
        if (cmd.miss)
        begin
            miss_reg <= 1'b1;
        end
        if (cmd.out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

FILE: rtl/core/grc_ctrl.sv
// grc_ctrl: sequencer for clearing, cast setup, dda walk and result hand-off
// depends on grc_pkg; drives grc_datapath through cmd_t, reads status_t
`timescale 1ns / 1ps

module grc_ctrl
    import grc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  logic [1:0] item_mode,
    output logic       item_ready,
    input  status_t    st,
    output cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;
    op_t    op_reg;
    op_t    op_next;
    logic   axis_reg;
    logic   axis_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            op_reg    <= OP_CAM;
            axis_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            axis_reg  <= axis_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        axis_next  = axis_reg;
        item_ready = 1'b0;
        cmd        = '0;
        cmd.op     = op_reg;
        cmd.axis   = axis_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (st.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.accept = 1'b1;
                    if (item_mode == MODE_CAST)
                    begin
                        op_next    = OP_CAM;
                        axis_next  = 1'b0;
                        state_next = S_ISSUE;
                    end
                end
            end
            S_ISSUE:
            begin
                cmd.start  = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (st.done)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_ISSUE;
                    axis_next   = 1'b0;
                    case (op_reg)
                        OP_CAM:
                        begin
                            op_next = OP_RAY;
                        end
                        OP_RAY:
                        begin
                            axis_next = !axis_reg;
                            op_next   = axis_reg ? OP_DELTA : OP_RAY;
                        end
                        OP_DELTA:
                        begin
                            axis_next = !axis_reg;
                            op_next   = axis_reg ? OP_SIDE : OP_DELTA;
                        end
                        OP_SIDE:
                        begin
                            axis_next = !axis_reg;
                            if (axis_reg)
                            begin
                                state_next = S_WALK_STEP;
                            end
                        end
                        OP_PERP:
                        begin
                            op_next = OP_LH;
                        end
                        OP_LH:
                        begin
                            state_next = S_OUT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_WALK_STEP:
            begin
                cmd.walk_step = 1'b1;
                state_next    = S_WALK_CHK;
            end
            S_WALK_CHK:
            begin
                if (st.out_of_map)
                begin
                    cmd.miss   = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_WALK_TEST;
                end
            end
            S_WALK_TEST:
            begin
                if (st.cell_nz)
                begin
                    cmd.hit    = 1'b1;
                    op_next    = OP_PERP;
                    state_next = S_ISSUE;
                end
                else if (st.walk_limit)
                begin
                    cmd.miss   = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_WALK_STEP;
                end
            end
            S_OUT:
            begin
                if (!st.out_full)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // units only finish while their result is awaited
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        st.done |-> state_reg == S_WAIT)
        else $error("unit finished outside wait");

    a_issue_then_wait: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ISSUE |=> state_reg == S_WAIT)
        else $error("issue not followed by wait");

    a_test_after_chk: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK_TEST |-> $past(state_reg) == S_WALK_CHK)
        else $error("cell test without read");

    a_load_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !st.out_full)
        else $error("result overwritten");

endmodule

FILE: rtl/core/grid_ray_cast_column.sv
// grid_ray_cast_column: top level of the column ray caster
// depends on grc_pkg, grc_stream_if, grc_ctrl, grc_datapath
`timescale 1ns / 1ps

// usage
// item channel: mode 0 writes one map cell, mode 2 sets the used map extent,
//   mode 1 casts one screen column; mode 3 is dropped
// result channel: one beat per cast, none for the other modes
// cfg channel: register index and data, always ready; write only while idle
// a cell write or extent beat is taken without leaving idle
// a cast runs on the shared one-bit-per-cycle divider (five divides)
//   and shift-add multiplier (four multiplies), with one memory read per cell walked
// one item is worked at a time; the next is taken once the result sits in
//   the output register, so a waiting result does not hold up the next item
// reset: registers take their reset values, then the grid memory is swept
//   to zero over all 2^(clog2(MAP_FIRST_MAX)+clog2(MAP_SECOND_MAX)) cells
//   (4096 by default) with item ready low
// receiver stall: the result holds in the output register; a later cast
//   finishes and waits until that register drains

module grid_ray_cast_column
    import grc_pkg::*;
#(
    parameter int MAP_FIRST_MAX  = 64,
    parameter int MAP_SECOND_MAX = 64,
    parameter int FRAC_BITS      = 16
)(
    input logic          clk,
    input logic          rst_n,
    grc_stream_if.sink   item,
    grc_stream_if.source result,
    grc_stream_if.sink   cfg
);

    cmd_t      cmd;
    status_t   st;
    in_item_t  item_data;
    cfg_beat_t cfg_data;
    out_item_t out_data;
    logic      item_ready;
    logic      out_valid;

    assign item_data      = item.payload;
    assign cfg_data       = cfg.payload;
    assign item.ready     = item_ready;
    assign cfg.ready      = 1'b1;
    assign result.valid   = out_valid;
    assign result.payload = out_data;

    grc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_mode  (item_data.mode),
        .item_ready (item_ready),
        .st         (st),
        .cmd        (cmd)
    );

    grc_datapath #(
        .MAP_FIRST_MAX  (MAP_FIRST_MAX),
        .MAP_SECOND_MAX (MAP_SECOND_MAX),
        .FRAC_BITS      (FRAC_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .item_data (item_data),
        .cfg_we    (cfg.valid),
        .cfg_data  (cfg_data),
        .out_ready (result.ready),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

FILE: tb/sv/grid_ray_cast_column_tb.sv
// grid_ray_cast_column_tb: self-checking bench for the column ray caster
// depends on grc_pkg, grc_stream_if and grid_ray_cast_column; a built-in
// DDA predictor checks every result beat, with and without random stalls on both sides
`timescale 1ns / 1ps

module grid_ray_cast_column_tb;
    import grc_pkg::*;

    localparam int  MAP_N     = 64;
    localparam int  FB        = 16;
    localparam int  WALK_MAX  = 2 * MAP_N;
    localparam longint ONE    = longint'(1) << FB;
    localparam longint DMAX   = 64'h0000_0000_FFFF_FFFF;
    localparam int  CYCLE_CAP = 3000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    grc_stream_if #(.T(in_item_t))  item_if();
    grc_stream_if #(.T(out_item_t)) res_if();
    grc_stream_if #(.T(cfg_beat_t)) cfg_if();

    grid_ray_cast_column dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if),
        .result (res_if),
        .cfg    (cfg_if)
    );

    always #4 clk = ~clk;

    logic [3:0]  grid_mirror [0:MAP_N*MAP_N-1];
    int          ext_first_m;
    int          ext_second_m;
    logic [31:0] reg_mirror [0:15];
    out_item_t   column_q [$];
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          errors;
    int          casts_sent;
    int          items_sent;
    int          walls_hit;
    int          cycles;

    initial begin
        item_if.valid = 1'b0;
        item_if.payload = '0;
        cfg_if.valid = 1'b0;
        cfg_if.payload = '0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(negedge clk)
        res_if.ready <= ($urandom_range(99) >= rx_idle_pct);

    function automatic longint abs64(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint sat32(longint v);
        return v > DMAX ? DMAX : v;
    endfunction

    function automatic out_item_t cast_column(logic [11:0] col);
        out_item_t r;
        longint pos [2];
        longint dir [2];
        longint pln [2];
        longint ray [2];
        longint cellp [2];
        longint stp [2];
        longint dlt [2];
        longint sd [2];
        longint wid, hgt, cam, frac, bnd, perp, lh, hh, hl, st, en, tex;
        int     side;
        bit     hit;
        pos[0] = longint'(reg_mirror[REG_POS_FIRST]);
        pos[1] = longint'(reg_mirror[REG_POS_SECOND]);
        dir[0] = longint'($signed(reg_mirror[REG_DIR_FIRST][17:0]));
        dir[1] = longint'($signed(reg_mirror[REG_DIR_SECOND][17:0]));
        pln[0] = longint'($signed(reg_mirror[REG_PLANE_FIRST][17:0]));
        pln[1] = longint'($signed(reg_mirror[REG_PLANE_SECOND][17:0]));
        wid = longint'(reg_mirror[REG_SCREEN_WIDTH][12:0]);
        hgt = longint'(reg_mirror[REG_SCREEN_HEIGHT][12:0]);
        if (wid == 0) wid = 1;
        if (hgt == 0) hgt = 1;
        if (hgt > 4096) hgt = 4096;
        cam = ((2 * longint'(col)) << FB) / wid - ONE;
        for (int k = 0; k < 2; k++)
        begin
            ray[k] = dir[k] + ((pln[k] * cam) >>> FB);
            dlt[k] = ray[k] == 0 ? DMAX : sat32((longint'(1) << (2 * FB)) / abs64(ray[k]));
            cellp[k] = pos[k] >> FB;
            frac = pos[k] & (ONE - 1);
            if (ray[k] < 0)
                stp[k] = -1;
            else
            begin
                stp[k] = 1;
                frac = ONE - frac;
            end
            sd[k] = sat32((frac * dlt[k]) >> FB);
        end
        side = 0;
        hit = 1'b0;
        for (int n = 0; n < WALK_MAX; n++)
        begin
            side = sd[0] < sd[1] ? 0 : 1;
            sd[side] = sat32(sd[side] + dlt[side]);
            cellp[side] += stp[side];
            if (cellp[0] < 0 || cellp[0] >= ext_first_m || cellp[1] < 0
                || cellp[1] >= ext_second_m)
                break;
            if (grid_mirror[12'(cellp[0] * MAP_N + cellp[1])] != 0)
            begin
                hit = 1'b1;
                break;
            end
        end
        r = '0;
        if (!hit)
        begin
            r.perp_dist = DIST_MAX;
            r.no_wall = 1'b1;
            return r;
        end
        bnd = (cellp[side] + (stp[side] < 0 ? 1 : 0)) * ONE;
        perp = ray[side] == 0 ? DMAX : sat32((abs64(bnd - pos[side]) << FB) / abs64(ray[side]));
        lh = perp == 0 ? 65535 : (hgt << FB) / perp;
        if (lh > 65535) lh = 65535;
        hh = hgt / 2;
        hl = lh / 2;
        st = hh - hl;
        en = hh + hl;
        if (st < 0) st = 0;
        if (en >= hgt) en = hgt - 1;
        tex = longint'(grid_mirror[12'(cellp[0] * MAP_N + cellp[1])]) - 1;
        if (cellp[0] == 0) tex = TEX_FIRST_LOW;
        if (cellp[0] == ext_first_m - 1) tex = TEX_FIRST_HIGH;
        if (cellp[1] == 0) tex = TEX_SECOND_LOW;
        if (cellp[1] == ext_second_m - 1) tex = TEX_SECOND_HIGH;
        r.perp_dist = perp[31:0];
        r.line_height = lh[15:0];
        r.draw_start = st[11:0];
        r.draw_end = en[11:0];
        r.hit_side = side[0];
        r.hit_first = cellp[0][5:0];
        r.hit_second = cellp[1][5:0];
        r.texture_index = tex[3:0];
        return r;
    endfunction

    function automatic int clamp_ext(logic [6:0] v);
        if (v == 0) return 1;
        return v > MAP_N ? MAP_N : int'(v);
    endfunction

    // track block state at the accepting edge
    function automatic void item_taken(in_item_t it);
        case (it.mode)
            MODE_WRITE:
                grid_mirror[{it.cell_first, it.cell_second}] = it.cell_value;
            MODE_EXTENT:
            begin
                ext_first_m = clamp_ext(it.extent_first);
                ext_second_m = clamp_ext(it.extent_second);
            end
            MODE_CAST:
            begin
                column_q.push_back(cast_column(it.column));
                casts_sent++;
            end
            default: ;
        endcase
        items_sent++;
    endfunction

    task automatic send_item(in_item_t it);
        @(negedge clk);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            item_if.valid = 1'b0;
            do @(negedge clk); while ($urandom_range(99) < tx_idle_pct);
        end
        item_if.valid = 1'b1;
        item_if.payload = it;
        @(posedge clk);
        while (!item_if.ready) @(posedge clk);
        item_taken(it);
    endtask

    task automatic field_check(string name, longint want, longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        out_item_t w;
        out_item_t g;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            g = res_if.payload;
            if (column_q.size() == 0)
            begin
                $error("result beat with nothing expected");
                errors++;
            end
            else
            begin
                w = column_q.pop_front();
                if (!w.no_wall) walls_hit++;
                field_check("perp_dist", w.perp_dist, g.perp_dist);
                field_check("line_height", w.line_height, g.line_height);
                field_check("draw_start", w.draw_start, g.draw_start);
                field_check("draw_end", w.draw_end, g.draw_end);
                field_check("hit_side", w.hit_side, g.hit_side);
                field_check("hit_first", w.hit_first, g.hit_first);
                field_check("hit_second", w.hit_second, g.hit_second);
                field_check("texture_index", w.texture_index, g.texture_index);
                field_check("no_wall", w.no_wall, g.no_wall);
            end
        end
    end

    // wait until the block is idle before touching registers
    task automatic wait_idle();
        @(negedge clk);
        item_if.valid = 1'b0;
        while (column_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [3:0] idx, logic [31:0] data);
        int w;
        case (idx)
            REG_POS_FIRST, REG_POS_SECOND: w = 32;
            REG_SCREEN_WIDTH, REG_SCREEN_HEIGHT: w = 13;
            default: w = 18;
        endcase
        @(negedge clk);
        cfg_if.valid = 1'b1;
        cfg_if.payload.index = idx;
        cfg_if.payload.data = data;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        reg_mirror[idx] = w == 32 ? data : data & ((32'd1 << w) - 1);
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    function automatic in_item_t noise_item(logic [1:0] m);
        in_item_t it;
        it = in_item_t'({$urandom, $urandom});
        it.mode = m;
        return it;
    endfunction

    task automatic put_cell(int a, int b, int v);
        in_item_t it;
        it = noise_item(MODE_WRITE);
        it.cell_first = 6'(a);
        it.cell_second = 6'(b);
        it.cell_value = 4'(v);
        send_item(it);
    endtask

    task automatic put_extent(int a, int b);
        in_item_t it;
        it = noise_item(MODE_EXTENT);
        it.extent_first = 7'(a);
        it.extent_second = 7'(b);
        send_item(it);
    endtask

    task automatic put_cast(int col);
        in_item_t it;
        it = noise_item(MODE_CAST);
        it.column = 12'(col);
        send_item(it);
    endtask

    task automatic test_directed();
        // reset registers give a zero ray: walk runs straight off the map
        put_cast(0);
        put_cast(4095);
        put_extent(0, 0);
        put_cast(320);
        put_extent(127, 127);
        put_cell(63, 63, 15);
        put_cell(0, 5, 1);
        put_cell(5, 0, 2);
        put_cell(63, 0, 3);
        put_cell(3, 63, 7);
        send_item(noise_item(2'd3));
        wait_idle();
        write_reg(REG_POS_FIRST, 32'h0002_8000);
        write_reg(REG_POS_SECOND, 32'h0002_4000);
        write_reg(REG_DIR_FIRST, 32'hFFFE_0000);
        write_reg(REG_DIR_SECOND, 32'h0);
        write_reg(REG_PLANE_FIRST, 32'h0);
        write_reg(REG_PLANE_SECOND, 32'h0001_FFFF);
        write_reg(REG_SCREEN_WIDTH, 32'd0);
        write_reg(REG_SCREEN_HEIGHT, 32'd0);
        put_cast(0);
        put_cast(1);
        wait_idle();
        write_reg(REG_DIR_FIRST, 32'h0001_FFFF);
        write_reg(REG_SCREEN_WIDTH, 32'd4096);
        write_reg(REG_SCREEN_HEIGHT, 32'h1FFF);
        put_cast(2048);
        put_cast(4095);
        put_extent(64, 64);
        wait_idle();
        // start cell far outside the map
        write_reg(REG_POS_FIRST, 32'hFFFF_FFFF);
        write_reg(REG_POS_SECOND, 32'h8000_0000);
        put_cast(100);
        wait_idle();
        // viewer right against a wall: tiny distance, saturated height
        write_reg(REG_POS_FIRST, 32'h0003_FFFF);
        write_reg(REG_POS_SECOND, 32'h0003_8000);
        write_reg(REG_DIR_FIRST, 32'h0001_0000);
        write_reg(REG_DIR_SECOND, 32'h0);
        write_reg(REG_PLANE_FIRST, 32'h0);
        write_reg(REG_PLANE_SECOND, 32'h0);
        write_reg(REG_SCREEN_HEIGHT, 32'd4096);
        put_cell(4, 3, 9);
        put_cast(7);
        wait_idle();
    endtask

    task automatic random_regs();
        int ef;
        int es;
        ef = ext_first_m;
        es = ext_second_m;
        if ($urandom_range(9) == 0)
        begin
            write_reg(REG_POS_FIRST, $urandom);
            write_reg(REG_POS_SECOND, $urandom);
        end
        else
        begin
            write_reg(REG_POS_FIRST, ($urandom_range(ef - 1) << FB) | $urandom_range(16'hFFFF));
            write_reg(REG_POS_SECOND, ($urandom_range(es - 1) << FB) | $urandom_range(16'hFFFF));
        end
        for (int k = REG_DIR_FIRST; k <= REG_PLANE_SECOND; k++)
            case ($urandom_range(5))
                0: write_reg(4'(k), $urandom);
                1: write_reg(4'(k), $urandom_range(1) ? 32'h0002_0000 : 32'h0001_FFFF);
                2: write_reg(4'(k), 32'h0);
                default: write_reg(4'(k), $urandom_range(65536 * 2) - 65536);
            endcase
        case ($urandom_range(5))
            0: write_reg(REG_SCREEN_WIDTH, $urandom);
            1: write_reg(REG_SCREEN_WIDTH, $urandom_range(1) ? 1 : 4096);
            default: write_reg(REG_SCREEN_WIDTH, $urandom_range(4096, 1));
        endcase
        case ($urandom_range(5))
            0: write_reg(REG_SCREEN_HEIGHT, $urandom);
            1: write_reg(REG_SCREEN_HEIGHT, $urandom_range(1) ? 1 : 4096);
            default: write_reg(REG_SCREEN_HEIGHT, $urandom_range(4096, 1));
        endcase
    endtask

    // one scene: extent, some walls, random registers, then a run of columns
    task automatic random_scene();
        int ef;
        int es;
        int wid;
        if ($urandom_range(7) == 0)
            put_extent($urandom_range(127), $urandom_range(127));
        else
            put_extent($urandom_range(12, 4), $urandom_range(12, 4));
        ef = ext_first_m;
        es = ext_second_m;
        repeat ($urandom_range(14, 6))
            if ($urandom_range(9) == 0)
                put_cell($urandom_range(63), $urandom_range(63), $urandom_range(15));
            else
                put_cell($urandom_range(ef - 1), $urandom_range(es - 1),
                         $urandom_range(3) == 0 ? 0 : $urandom_range(15, 1));
        wait_idle();
        random_regs();
        wid = int'(reg_mirror[REG_SCREEN_WIDTH][12:0]);
        if (wid == 0) wid = 1;
        if (wid > 4096) wid = 4096;
        repeat ($urandom_range(10, 4))
            case ($urandom_range(15))
                0: send_item(noise_item(2'd3));
                1: put_cast($urandom_range(4095));
                default: put_cast($urandom_range(wid - 1));
            endcase
        wait_idle();
    endtask

    task automatic test_random(int tx, int rx, int n_items);
        int goal;
        tx_idle_pct = tx;
        rx_idle_pct = rx;
        goal = items_sent + n_items;
        while (items_sent < goal) random_scene();
    endtask

    initial begin
        for (int i = 0; i < MAP_N * MAP_N; i++) grid_mirror[i] = '0;
        for (int i = 0; i < 16; i++) reg_mirror[i] = '0;
        reg_mirror[REG_SCREEN_WIDTH] = WIDTH_RST;
        reg_mirror[REG_SCREEN_HEIGHT] = HEIGHT_RST;
        ext_first_m = EXTENT_RST;
        ext_second_m = EXTENT_RST;
        errors = 0;
        casts_sent = 0;
        items_sent = 0;
        walls_hit = 0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random(11, 76, 210);
        test_random(76, 11, 210);
        test_random(0, 0, 210);
        wait_idle();
        repeat (1000) @(posedge clk);
        if (column_q.size() != 0)
        begin
            $error("%0d expected results never arrived", column_q.size());
            errors++;
        end
        $display("run: %0d items, %0d column casts, %0d reached a wall",
                 items_sent, casts_sent, walls_hit);
        $display("stalls swept on both channels, registers cycled through extremes");
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
